// ----- hdl/lbp_pkg.sv -----
`default_nettype none
package lbp_pkg;

  localparam int unsigned PIX_W   = 12;
  localparam int unsigned GREY_W  = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned BLKNO_W = 6;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned GAP_W   = 8;
  localparam int unsigned EDGE_W  = 7;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned NB_MAX  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CIDX_W-1:0] {
    REG_GAP_ROW     = 3'd0,
    REG_GAP_COL     = 3'd1,
    REG_BLOCK_EDGE  = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_INDEX,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/lbp_divider.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lbp_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lbp_pkg::PIX_W-1:0]     dividend,
  input  wire logic [lbp_pkg::EDGE_W-1:0]    divisor,
  output logic                               done,
  output logic [lbp_pkg::PIX_W-1:0]          quotient
);

  localparam int unsigned CNT_W = $clog2(lbp_pkg::PIX_W);

  logic                        busy;
  logic [CNT_W-1:0]            count;
  logic [lbp_pkg::EDGE_W-1:0]  dvsr;
  logic [lbp_pkg::EDGE_W-1:0]  rem;
  logic [lbp_pkg::EDGE_W:0]    rem_shift;
  logic                        ge;

  always_comb begin
    rem_shift = {rem, quotient[lbp_pkg::PIX_W-1]};
    ge        = (rem_shift >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(lbp_pkg::PIX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      rem      <= ge ? lbp_pkg::EDGE_W'(rem_shift - {1'b0, dvsr})
                     : lbp_pkg::EDGE_W'(rem_shift);
      quotient <= {quotient[lbp_pkg::PIX_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lbp_bin_store.sv -----
`default_nettype none
// Histogram counters; swept to zero after reset, then read and written
// at one shared address.
module lbp_bin_store #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DEPTH  = 16384
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lbp_pkg::store_cmd_t           cmd,
  input  wire logic [ADDR_W-1:0]             addr,
  input  wire logic [lbp_pkg::COUNT_W-1:0]   wr_data,
  output logic [lbp_pkg::COUNT_W-1:0]        rd_data,
  output logic                               ready
);

  logic [lbp_pkg::COUNT_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]           clr_ptr;
  logic                        clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= '0;
    end else if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign ready = !clearing;

endmodule
`default_nettype wire

// ----- hdl/lbp_block_histogram.sv -----
`default_nettype none
// Channel   Handshake            Payload
// input     in_valid/in_ready    pixel_row, pixel_col, center_value, neighbor_0..7
// output    out_valid/out_ready  pattern_code, block_number, bin_count, outside_grid
// config    cfg_we               cfg_index, cfg_data
//
// Counted pixel: bit-serial row and column dividers, then index, counter read,
// counter write, output load, then idle for the next request. Flagged before
// the dividers: straight to output load; flagged against the grid: output load
// after the dividers and index. After reset the counter memory, MAX_BLOCKS <<
// NUM_SAMPLES counters, is swept to zero with in_ready low. A waiting result
// stalls the block only at its final step.
module lbp_block_histogram #(
  parameter int unsigned NUM_SAMPLES = 8,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lbp_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [lbp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lbp_pkg::PIX_W-1:0]     pixel_row,
  input  wire logic [lbp_pkg::PIX_W-1:0]     pixel_col,
  input  wire logic [lbp_pkg::GREY_W-1:0]    center_value,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_0,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_1,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_2,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_3,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_4,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_5,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_6,
  input  wire logic [lbp_pkg::GREY_W-1:0]    neighbor_7,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lbp_pkg::CODE_W-1:0]         pattern_code,
  output logic [lbp_pkg::BLKNO_W-1:0]        block_number,
  output logic [lbp_pkg::COUNT_W-1:0]        bin_count,
  output logic                               outside_grid
);

  localparam int unsigned BLK_BITS = $clog2(MAX_BLOCKS);
  localparam int unsigned ADDR_W   = BLK_BITS + NUM_SAMPLES;
  localparam int unsigned DEPTH    = MAX_BLOCKS << NUM_SAMPLES;
  localparam int unsigned IDX_W    = 2 * lbp_pkg::EDGE_W + 1;

  // configuration registers
  logic [lbp_pkg::GAP_W-1:0]  gap_row;
  logic [lbp_pkg::GAP_W-1:0]  gap_col;
  logic [lbp_pkg::EDGE_W-1:0] block_edge;
  logic [lbp_pkg::EDGE_W-1:0] grid_width;
  logic [lbp_pkg::EDGE_W-1:0] grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_row     <= '0;
      gap_col     <= '0;
      block_edge  <= lbp_pkg::EDGE_W'(16);
      grid_width  <= lbp_pkg::EDGE_W'(4);
      grid_height <= lbp_pkg::EDGE_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbp_pkg::REG_GAP_ROW:     gap_row     <= cfg_data;
        lbp_pkg::REG_GAP_COL:     gap_col     <= cfg_data;
        lbp_pkg::REG_BLOCK_EDGE:  block_edge  <= cfg_data[lbp_pkg::EDGE_W-1:0];
        lbp_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[lbp_pkg::EDGE_W-1:0];
        lbp_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[lbp_pkg::EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  // comparator lanes, one per neighbor; merged into the pattern word
  logic [lbp_pkg::GREY_W-1:0] nb [lbp_pkg::NB_MAX];
  logic [NUM_SAMPLES-1:0]     lane_hit;
  logic [lbp_pkg::CODE_W-1:0] code_in;

  assign nb[0] = neighbor_0;
  assign nb[1] = neighbor_1;
  assign nb[2] = neighbor_2;
  assign nb[3] = neighbor_3;
  assign nb[4] = neighbor_4;
  assign nb[5] = neighbor_5;
  assign nb[6] = neighbor_6;
  assign nb[7] = neighbor_7;

  for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_lane
    assign lane_hit[NUM_SAMPLES-1-i] = (center_value <= nb[i]);
  end

  assign code_in = lbp_pkg::CODE_W'(lane_hit);

  // control
  lbp_pkg::state_t    state, state_next;
  lbp_pkg::store_cmd_t store_cmd;
  logic               accept;
  logic               before_gap;
  logic               div_start;
  logic               div_row_done, div_col_done;
  logic               out_load;
  logic               store_ready;

  logic [lbp_pkg::PIX_W-1:0]   row_quo, col_quo;
  logic [lbp_pkg::CODE_W-1:0]  code;
  logic                        outside;
  logic [lbp_pkg::EDGE_W-1:0]  blk_row, blk_col;
  logic [IDX_W-1:0]            blk_full;
  logic [IDX_W-1:0]            blk;
  logic [ADDR_W-1:0]           addr;
  logic [lbp_pkg::COUNT_W-1:0] count;
  logic [lbp_pkg::COUNT_W-1:0] rd_data;
  logic [lbp_pkg::COUNT_W-1:0] count_inc;

  assign accept     = in_valid && in_ready;
  assign before_gap = (pixel_row < lbp_pkg::PIX_W'(gap_row))
                   || (pixel_col < lbp_pkg::PIX_W'(gap_col))
                   || (block_edge == '0);
  assign blk_full   = IDX_W'(blk_row * grid_width) + IDX_W'(blk_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lbp_pkg::ST_IDLE:   if (accept) begin
                            state_next = before_gap ? lbp_pkg::ST_DONE
                                                    : lbp_pkg::ST_DIVIDE;
                          end
      lbp_pkg::ST_DIVIDE: if (div_row_done && div_col_done) begin
                            state_next = lbp_pkg::ST_INDEX;
                          end
      lbp_pkg::ST_INDEX:  state_next = (outside || (blk_full >= IDX_W'(MAX_BLOCKS)))
                                     ? lbp_pkg::ST_DONE : lbp_pkg::ST_READ;
      lbp_pkg::ST_READ:   state_next = lbp_pkg::ST_WRITE;
      lbp_pkg::ST_WRITE:  state_next = lbp_pkg::ST_DONE;
      lbp_pkg::ST_DONE:   if (!out_valid || out_ready) begin
                            state_next = lbp_pkg::ST_IDLE;
                          end
      default:            state_next = lbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    div_start       = 1'b0;
    store_cmd.rd_en = 1'b0;
    store_cmd.wr_en = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      lbp_pkg::ST_IDLE: begin
        in_ready  = store_ready;
        div_start = accept && !before_gap;
      end
      lbp_pkg::ST_READ:  store_cmd.rd_en = 1'b1;
      lbp_pkg::ST_WRITE: store_cmd.wr_en = 1'b1;
      lbp_pkg::ST_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      lbp_pkg::ST_IDLE: begin
        code    <= code_in;
        outside <= before_gap;
        blk     <= '0;
        count   <= '0;
      end
      lbp_pkg::ST_DIVIDE: begin
        // register the quotients and flag a block outside the grid
        outside <= (row_quo >= lbp_pkg::PIX_W'(grid_height))
                || (col_quo >= lbp_pkg::PIX_W'(grid_width));
        blk_row <= row_quo[lbp_pkg::EDGE_W-1:0];
        blk_col <= col_quo[lbp_pkg::EDGE_W-1:0];
      end
      lbp_pkg::ST_INDEX: begin
        if (outside || (blk_full >= IDX_W'(MAX_BLOCKS))) begin
          outside <= 1'b1;
          blk     <= '0;
        end else begin
          blk  <= blk_full;
          addr <= ADDR_W'({blk_full, code[NUM_SAMPLES-1:0]});
        end
      end
      lbp_pkg::ST_WRITE: count <= count_inc;
      default: ;
    endcase
  end

  assign count_inc = (rd_data == lbp_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;

  lbp_divider u_div_row (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pixel_row - lbp_pkg::PIX_W'(gap_row)),
    .divisor  (block_edge),
    .done     (div_row_done),
    .quotient (row_quo)
  );

  lbp_divider u_div_col (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pixel_col - lbp_pkg::PIX_W'(gap_col)),
    .divisor  (block_edge),
    .done     (div_col_done),
    .quotient (col_quo)
  );

  lbp_bin_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (store_cmd),
    .addr    (addr),
    .wr_data (count_inc),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pattern_code <= code;
      block_number <= blk[lbp_pkg::BLKNO_W-1:0];
      bin_count    <= outside ? '0 : count;
      outside_grid <= outside;
    end
  end

endmodule
`default_nettype wire
